// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operand widths, command codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int MagWidth     = 2 * OperandWidth + 1;
  localparam int NumWidth     = 33;
  localparam int DenWidth     = 31;
  localparam int CntWidth     = $clog2(MagWidth + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic [1:0]                     command;
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NumWidth-1:0] res_num;
    logic [DenWidth-1:0]        res_den;
    logic                       status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMBINE,
    ST_GCD_START,
    ST_GCD_WAIT,
    ST_DIVN_START,
    ST_DIVN_WAIT,
    ST_DIVD_START,
    ST_DIVD_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply or divide two fractions
// Forms cross products, reduces by the GCD and normalizes the sign.
// ----------------------------------------------------------------------------
//  channel   | ports                        | transfer
//  ----------+------------------------------+-------------------------------
//  command   | start, busy, operands        | start high while busy low
//  result    | result_valid, result         | one cycle strobe, no stall
//
// An item takes three multiply steps, a combine step, a GCD launch, a binary
// GCD, two divisions (launch, quotient bits, finish) on the shared restoring
// divider and a done state, which raises the strobe. Errors go from the
// transfer straight to the done state, zero numerators from the GCD launch.
// Reset clears the sequencer; busy is low afterward. The receiver cannot
// stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rau_pkg::in_item_t  operands,
  output logic               busy,
  output logic               result_valid,
  output rau_pkg::out_item_t result
);

  localparam int W = rau_pkg::OperandWidth;
  localparam int M = rau_pkg::MagWidth;

  rau_pkg::state_t state, state_next;

  // Operand magnitudes and signs, captured at the transfer.
  logic [W-1:0] an, ad, bn, bd;
  logic         an_s, ad_s, bn_s, bd_s;
  logic [1:0]   cmd;
  logic [2*W-1:0] p1, p2, pd;
  logic [M-1:0] n_mag, d_mag, g, n_red;
  logic         n_neg, d_neg;

  // Shared multiplier: one product per cycle.
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? W'(~v + 1'b1) : v;
  endfunction

  logic gcd_start, gcd_done, div_start, div_done;
  logic [M-1:0] gcd_out, div_a, div_q;

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start), .x(n_mag), .y(d_mag),
    .done(gcd_done), .result(gcd_out)
  );

  rau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(g),
    .done(div_done), .quotient(div_q)
  );

  logic in_err;
  assign in_err = (operands.a_den == '0) || (operands.b_den == '0) ||
                  (operands.command == rau_pkg::CMD_DIV && operands.b_num == '0);

  // Operand pairs for each multiply step.
  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (state)
      rau_pkg::ST_MUL1: begin
        mul_a = (cmd == rau_pkg::CMD_MUL) ? an : an;
        mul_b = (cmd == rau_pkg::CMD_MUL) ? bn : bd;
      end
      rau_pkg::ST_MUL2: begin
        mul_a = ad;
        mul_b = (cmd == rau_pkg::CMD_DIV) ? bn : bd;
      end
      rau_pkg::ST_MUL3: begin
        mul_a = ad;
        mul_b = bn;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    gcd_start  = 1'b0;
    div_start  = 1'b0;
    div_a      = n_mag;
    unique case (state)
      rau_pkg::ST_IDLE:
        if (start) begin
          state_next = in_err ? rau_pkg::ST_DONE : rau_pkg::ST_MUL1;
        end
      rau_pkg::ST_MUL1: state_next = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2: state_next = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3: state_next = rau_pkg::ST_COMBINE;
      rau_pkg::ST_COMBINE: state_next = rau_pkg::ST_GCD_START;
      // n_mag is settled here; a zero numerator skips the reduction.
      rau_pkg::ST_GCD_START:
        if (n_mag == '0) begin
          state_next = rau_pkg::ST_DONE;
        end else begin
          gcd_start  = 1'b1;
          state_next = rau_pkg::ST_GCD_WAIT;
        end
      rau_pkg::ST_GCD_WAIT:
        if (gcd_done) state_next = rau_pkg::ST_DIVN_START;
      rau_pkg::ST_DIVN_START: begin
        div_start  = 1'b1;
        div_a      = n_mag;
        state_next = rau_pkg::ST_DIVN_WAIT;
      end
      rau_pkg::ST_DIVN_WAIT:
        if (div_done) state_next = rau_pkg::ST_DIVD_START;
      rau_pkg::ST_DIVD_START: begin
        div_start  = 1'b1;
        div_a      = d_mag;
        state_next = rau_pkg::ST_DIVD_WAIT;
      end
      rau_pkg::ST_DIVD_WAIT:
        if (div_done) state_next = rau_pkg::ST_DONE;
      rau_pkg::ST_DONE: state_next = rau_pkg::ST_IDLE;
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic s1, s2;
  assign s1 = an_s ^ bd_s;
  assign s2 = (ad_s ^ bn_s) ^ (cmd == rau_pkg::CMD_SUB);

  // Datapath registers; hold when not addressed by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == rau_pkg::ST_DONE);
    end
    unique case (state)
      rau_pkg::ST_IDLE:
        if (start) begin
          cmd   <= operands.command;
          an    <= mag_of(operands.a_num);
          ad    <= mag_of(operands.a_den);
          bn    <= mag_of(operands.b_num);
          bd    <= mag_of(operands.b_den);
          an_s  <= operands.a_num[W-1];
          ad_s  <= operands.a_den[W-1];
          bn_s  <= operands.b_num[W-1];
          bd_s  <= operands.b_den[W-1];
          result.res_num <= '0;
          result.res_den <= rau_pkg::DenWidth'(1);
          result.status  <= in_err;
        end
      rau_pkg::ST_MUL1: p1 <= mul_p;
      rau_pkg::ST_MUL2: pd <= mul_p;
      rau_pkg::ST_MUL3: p2 <= mul_p;
      rau_pkg::ST_COMBINE: begin
        d_mag <= M'(pd);
        if (cmd == rau_pkg::CMD_MUL) begin
          n_mag <= M'(p1);
          n_neg <= an_s ^ bn_s;
          d_neg <= ad_s ^ bd_s;
        end else if (cmd == rau_pkg::CMD_DIV) begin
          n_mag <= M'(p1);
          n_neg <= an_s ^ bd_s;
          d_neg <= ad_s ^ bn_s;
        end else begin
          d_neg <= ad_s ^ bd_s;
          if (s1 == s2) begin
            n_mag <= M'(p1) + M'(p2);
            n_neg <= s1;
          end else if (p1 >= p2) begin
            n_mag <= M'(p1 - p2);
            n_neg <= s1;
          end else begin
            n_mag <= M'(p2 - p1);
            n_neg <= s2;
          end
        end
      end
      rau_pkg::ST_GCD_WAIT: if (gcd_done) g <= gcd_out;
      rau_pkg::ST_DIVN_WAIT: if (div_done) n_red <= div_q;
      rau_pkg::ST_DIVD_WAIT:
        if (div_done) begin
          result.res_num <= (n_neg ^ d_neg) ? rau_pkg::NumWidth'(~n_red + 1'b1)
                                            : rau_pkg::NumWidth'(n_red);
          result.res_den <= rau_pkg::DenWidth'(div_q);
        end
      default: ;
    endcase
  end

  // In the divide step for division, pd holds ad*bn; otherwise ad*bd.
  assign busy = (state != rau_pkg::ST_IDLE);

  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && start) |=> state != rau_pkg::ST_MUL1 || $past(state) == rau_pkg::ST_IDLE)
    else $error("item taken while busy");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.res_den != '0) else $error("zero denominator out");

endmodule

// ===== hdl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary greatest common divisor
// One subtract/compare/shift step per cycle over magnitudes of MagWidth bits.
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rau_pkg::MagWidth-1:0]  x,
  input  logic [rau_pkg::MagWidth-1:0]  y,
  output logic                          done,
  output logic [rau_pkg::MagWidth-1:0]  result
);

  logic [rau_pkg::MagWidth-1:0] u, v, u_next, v_next;
  logic [rau_pkg::CntWidth-1:0] shift, shift_next;
  logic                         running, running_next;

  // Step rules: strip common twos, strip twos from either, then subtract.
  always_comb begin
    u_next       = u;
    v_next       = v;
    shift_next   = shift;
    running_next = running;
    if (start) begin
      u_next       = x;
      v_next       = y;
      shift_next   = '0;
      running_next = 1'b1;
    end else if (running) begin
      priority if (v == '0) begin
        running_next = 1'b0;
      end else if (u == '0) begin
        u_next       = v;
        v_next       = '0;
        running_next = 1'b0;
      end else if (!u[0] && !v[0]) begin
        u_next     = u >> 1;
        v_next     = v >> 1;
        shift_next = shift + 1'b1;
      end else if (!u[0]) begin
        u_next = u >> 1;
      end else if (!v[0]) begin
        v_next = v >> 1;
      end else if (u >= v) begin
        u_next = (u - v) >> 1;
      end else begin
        v_next = (v - u) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else begin
      running <= running_next;
    end
    u     <= u_next;
    v     <= v_next;
    shift <= shift_next;
  end

  assign done   = running && (u == '0 || v == '0);
  assign result = (u | v) << shift;

endmodule

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: restoring divider, one quotient bit per cycle
// Divides a MagWidth-bit magnitude by a nonzero divisor.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rau_pkg::MagWidth-1:0]  dividend,
  input  logic [rau_pkg::MagWidth-1:0]  divisor,
  output logic                          done,
  output logic [rau_pkg::MagWidth-1:0]  quotient
);

  logic [rau_pkg::MagWidth-1:0] rem, quo, dsr;
  logic [rau_pkg::MagWidth:0]   trial;
  logic [rau_pkg::CntWidth-1:0] cnt;
  logic                         running;

  assign trial = {rem, quo[rau_pkg::MagWidth-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= rau_pkg::CntWidth'(rau_pkg::MagWidth);
    end else if (running && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end else begin
      running <= 1'b0;
    end
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running && cnt != '0) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= rau_pkg::MagWidth'(trial - {1'b0, dsr});
        quo <= {quo[rau_pkg::MagWidth-2:0], 1'b1};
      end else begin
        rem <= trial[rau_pkg::MagWidth-1:0];
        quo <= {quo[rau_pkg::MagWidth-2:0], 1'b0};
      end
    end
  end

  assign done     = running && cnt == '0;
  assign quotient = quo;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rational arithmetic unit
// Drives fraction pairs and commands through the start/busy handshake,
// predicts the reduced signed fraction for each transfer and compares every
// strobed result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  operands;
  logic      busy;
  logic      result_valid;
  out_item_t result;

  bit last_part;

  rational_arithmetic_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operands     (operands),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  // Fraction scoreboard: computes the reduced fraction for each accepted
  // transfer and holds it until the matching result strobe arrives.
  class fraction_scoreboard;
    out_item_t pending_fractions[$];
    int        mismatch_count;

    // Greatest common divisor by Euclid on plain magnitudes.
    function longint unsigned common_divisor(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function out_item_t reduce_fraction(in_item_t op);
      out_item_t       res;
      bit              an_neg, ad_neg, bn_neg, bd_neg, s1, s2, num_neg, den_neg;
      longint unsigned an, ad, bn, bd, p1, p2, num_mag, den_mag, g;
      longint          sn;
      an_neg = op.a_num[OperandWidth-1];
      ad_neg = op.a_den[OperandWidth-1];
      bn_neg = op.b_num[OperandWidth-1];
      bd_neg = op.b_den[OperandWidth-1];
      // Magnitudes of the two's complement operands; the most negative
      // value keeps its full magnitude.
      an = an_neg ? -longint'(op.a_num) : longint'(op.a_num);
      ad = ad_neg ? -longint'(op.a_den) : longint'(op.a_den);
      bn = bn_neg ? -longint'(op.b_num) : longint'(op.b_num);
      bd = bd_neg ? -longint'(op.b_den) : longint'(op.b_den);
      res.res_num = '0;
      res.res_den = 1;
      res.status  = STATUS_OK;
      // Zero denominator, or divide by a zero fraction: flag it, give 0/1.
      if (ad == 0 || bd == 0 || (cmd_t'(op.command) == CMD_DIV && bn == 0)) begin
        res.status = STATUS_ERR;
        return res;
      end
      case (cmd_t'(op.command))
        CMD_ADD, CMD_SUB: begin
          s1 = an_neg ^ bd_neg;
          s2 = (ad_neg ^ bn_neg) ^ (cmd_t'(op.command) == CMD_SUB);
          p1 = an * bd;
          p2 = ad * bn;
          if (s1 == s2) begin
            num_mag = p1 + p2;
            num_neg = s1;
          end else if (p1 >= p2) begin
            num_mag = p1 - p2;
            num_neg = s1;
          end else begin
            num_mag = p2 - p1;
            num_neg = s2;
          end
          den_mag = ad * bd;
          den_neg = ad_neg ^ bd_neg;
        end
        CMD_MUL: begin
          num_mag = an * bn;
          num_neg = an_neg ^ bn_neg;
          den_mag = ad * bd;
          den_neg = ad_neg ^ bd_neg;
        end
        default: begin
          num_mag = an * bd;
          num_neg = an_neg ^ bd_neg;
          den_mag = ad * bn;
          den_neg = ad_neg ^ bn_neg;
        end
      endcase
      // Zero numerator reduces to 0/1.
      if (num_mag == 0) return res;
      g = common_divisor(num_mag, den_mag);
      num_mag = num_mag / g;
      den_mag = den_mag / g;
      sn = (num_neg != den_neg) ? -longint'(num_mag) : longint'(num_mag);
      res.res_num = sn[NumWidth-1:0];
      res.res_den = den_mag[DenWidth-1:0];
      return res;
    endfunction

    function void note_transfer(in_item_t op);
      pending_fractions.push_back(reduce_fraction(op));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result num=%0d den=%0d status=%0d",
                   got.res_num, got.res_den, got.status);
        return;
      end
      want = pending_fractions.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                   want.res_num, want.res_den, want.status,
                   got.res_num, got.res_den, got.status);
      end
    endfunction
  endclass

  fraction_scoreboard fractions = new();

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run (~800 items plus idle bursts).
  initial begin
    #30000000;
    $display("Mismatches found");
    $finish;
  end

  // Sample results at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) fractions.check_result(result);
  end

  // Idle the command side for a random burst, except late in the run.
  task automatic idle_gap();
    int n;
    if (last_part || $urandom_range(0, 2) != 0) return;
    n = $urandom_range(1, 17);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one item and hold it until the block takes it; start stays high
  // into the next item unless an idle burst drops it.
  task automatic send_fraction_pair(in_item_t op);
    idle_gap();
    start    <= 1'b1;
    operands <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    fractions.note_transfer(op);
  endtask

  function automatic in_item_t make_item(cmd_t c, int an, int ad, int bn, int bd);
    in_item_t op;
    op.command = c;
    op.a_num   = an[OperandWidth-1:0];
    op.a_den   = ad[OperandWidth-1:0];
    op.b_num   = bn[OperandWidth-1:0];
    op.b_den   = bd[OperandWidth-1:0];
    return op;
  endfunction

  // Random operand: a mix of full-range values, small magnitudes and extremes.
  function automatic logic [OperandWidth-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3, 4, 5: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t op;
    rst      = 1'b1;
    start    = 1'b0;
    operands = '0;
    last_part = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command, field extremes, zero denominators, divide by
    // zero, zero results and sign handling.
    send_fraction_pair(make_item(CMD_ADD, 1, 2, 1, 3));
    send_fraction_pair(make_item(CMD_SUB, 1, 2, 1, 2));
    send_fraction_pair(make_item(CMD_MUL, -3, 4, 2, -9));
    send_fraction_pair(make_item(CMD_DIV, 5, -6, -10, 3));
    send_fraction_pair(make_item(CMD_ADD, 1, 0, 1, 1));
    send_fraction_pair(make_item(CMD_MUL, 1, 1, 1, 0));
    send_fraction_pair(make_item(CMD_DIV, 7, 3, 0, 5));
    send_fraction_pair(make_item(CMD_MUL, 0, 5, 7, 3));
    send_fraction_pair(make_item(CMD_ADD, -32768, -32768, -32768, -32768));
    send_fraction_pair(make_item(CMD_SUB, -32768, 32767, 32767, -32768));
    send_fraction_pair(make_item(CMD_MUL, -32768, 1, -32768, 1));
    send_fraction_pair(make_item(CMD_DIV, 32767, -32768, -32768, 32767));
    send_fraction_pair(make_item(CMD_ADD, 32767, 1, 32767, 1));
    send_fraction_pair(make_item(CMD_SUB, -32768, 1, 32767, 1));
    send_fraction_pair(make_item(CMD_DIV, -1, -1, -1, -1));
    send_fraction_pair(make_item(CMD_ADD, -1, 1, 1, 1));
    send_fraction_pair(make_item(CMD_DIV, 32767, 32767, 32767, 32767));
    send_fraction_pair(make_item(CMD_MUL, 21845, 10922, -10922, 21845));

    // Random: mixed magnitudes; the final stretch runs without idling.
    for (int i = 0; i < 750; i++) begin
      if (i == 650) last_part = 1'b1;
      op.command = cmd_t'($urandom_range(0, 3));
      op.a_num   = pick_operand();
      op.a_den   = pick_operand();
      op.b_num   = pick_operand();
      op.b_den   = pick_operand();
      send_fraction_pair(op);
    end
    start <= 1'b0;

    // Drain: wait for every prediction to be met, then a latency margin.
    fork
      while (fractions.pending_fractions.size() != 0) @(posedge clk);
      repeat (5000) @(posedge clk);
    join_any
    disable fork;
    repeat (200) @(posedge clk);
    if (fractions.mismatch_count == 0 && fractions.pending_fractions.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
